// ----- src/pns_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pns_pkg;

   // default table depth
   localparam int unsigned MAX_ENTRIES_DEF = 64;

   // fixed field widths
   localparam int unsigned ACT_W  = 3;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned CNT_W  = 7;
   localparam int unsigned EP_W   = 6;

   // largest count the count register can hold
   localparam int unsigned CNT_MAX = 127;

   // highest channel before wrap
   localparam logic [CNT_W-1:0] CHANNEL_TOP = 7'd99;

   typedef enum logic [ACT_W-1:0] {
      ACT_BUILD   = 3'd0,
      ACT_SHUFFLE = 3'd1,
      ACT_START   = 3'd2,
      ACT_NEXT    = 3'd3,
      ACT_PREV    = 3'd4
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BUILD,
      ST_SW_DIV,
      ST_SW_RD_A,
      ST_SW_RD_B,
      ST_SW_WR_A,
      ST_SW_WR_B,
      ST_NX_DIV,
      ST_RD_ISSUE,
      ST_RD_CHECK,
      ST_RESULT
   } state_type;

endpackage

`default_nettype wire

// ----- src/pns_mod.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial remainder unit: one dividend bit per cycle, restoring form.
module pns_mod (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [pns_pkg::WORD_W-1:0]  dividend,
   input  wire logic [pns_pkg::CNT_W-1:0]   divisor,
   output logic                             done,
   output logic [pns_pkg::CNT_W-1:0]        remainder
);
   import pns_pkg::*;

   localparam int unsigned STEP_W = $clog2(WORD_W);

   logic                run_ff;
   logic                done_ff;
   logic [STEP_W-1:0]   cnt_ff;
   logic [WORD_W-1:0]   quo_ff;
   logic [CNT_W-1:0]    rem_ff;
   logic [CNT_W-1:0]    div_ff;
   logic [CNT_W-1:0]    rem_in;
   logic [CNT_W:0]      trial;
   logic [CNT_W:0]      diff;

   // shift in the next dividend bit and subtract when it fits
   always_comb begin
      trial  = {rem_ff, quo_ff[WORD_W-1]};
      diff   = trial - {1'b0, div_ff};
      rem_in = diff[CNT_W] ? trial[CNT_W-1:0] : diff[CNT_W-1:0];
   end

   // sequence the steps
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(WORD_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // hold operands and partial remainder
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (run_ff) begin
         quo_ff <= {quo_ff[WORD_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ----- src/pns_tab.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Play-order table: one write port, one registered read port.
module pns_tab #(
   parameter int unsigned DEPTH = pns_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [$clog2(DEPTH)-1:0]   rd_data
);
   localparam int unsigned IW = $clog2(DEPTH);

   logic [IW-1:0] mem_ff [DEPTH];
   logic [IW-1:0] rd_ff;

   // write an entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // register the read word
   always_ff @(posedge clock) begin
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

`default_nettype wire

// ----- src/playlist_shuffle_navigator_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Playlist shuffle navigator. Holds a play-order table of entry numbers and
// handles one request word at a time; every request returns one response word
// with the selected entry, its valid flag, the channel and the shuffle status.
// A build writes as many entries as the entry count (saturated to the table
// depth); a shuffle step and next wait on the bit-serial remainder unit,
// while start, previous and an unknown action do not. A shuffle step at
// cursor zero and next on an empty playlist skip the remainder unit.
// req_stall stays
// high while a request is in progress; the response sits in an output register,
// so the following request can be taken while the response waits.
// csr_wdata (entry_count) may be written only while the block is idle.
module playlist_shuffle_navigator_core #(
   parameter int unsigned MAX_ENTRIES = pns_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic [pns_pkg::CNT_W-1:0]   csr_wdata,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [pns_pkg::ACT_W-1:0]   req_action,
   input  wire logic [pns_pkg::WORD_W-1:0]  req_random_word,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [pns_pkg::EP_W-1:0]         rsp_episode_index,
   output logic                             rsp_play_valid,
   output logic [pns_pkg::CNT_W-1:0]        rsp_channel_number,
   output logic                             rsp_shuffle_done
);
   import pns_pkg::*;

   // usable depth: the count register cannot go beyond CNT_MAX
   localparam int unsigned CAP = (MAX_ENTRIES < CNT_MAX) ? MAX_ENTRIES : CNT_MAX;
   localparam int unsigned IW  = $clog2(CAP);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] csr_ff;
   logic [CNT_W-1:0] pos_ff;
   logic [CNT_W-1:0] ch_ff;
   logic [CNT_W-1:0] cursor_ff;
   logic [CNT_W-1:0] slot_ff;
   logic [IW-1:0]    tmp_ff;
   logic             play_ok_ff;
   logic [IW-1:0]    ep_ff;
   logic             rsp_valid_ff;
   logic [EP_W-1:0]  rsp_ep_ff;
   logic             rsp_ok_ff;
   logic [CNT_W-1:0] rsp_ch_ff;
   logic             rsp_done_ff;

   logic [CNT_W-1:0] count;
   logic             accept;
   logic             out_free;
   logic [CNT_W-1:0] ch_wrap;
   logic [CNT_W-1:0] ch_next;
   logic [CNT_W-1:0] ch_prev;
   logic             look_ok;

   logic             tab_we;
   logic [IW-1:0]    tab_waddr;
   logic [IW-1:0]    tab_wdata;
   logic [IW-1:0]    tab_raddr;
   logic [IW-1:0]    tab_rdata;
   logic             div_start;
   logic [WORD_W-1:0] div_dividend;
   logic [CNT_W-1:0] div_divisor;
   logic             div_done;
   logic [CNT_W-1:0] div_rem;

   // saturate the count to the table depth
   assign count = (csr_ff > CNT_W'(CAP)) ? CNT_W'(CAP) : csr_ff;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // channel arithmetic
   always_comb begin
      ch_wrap = (ch_ff >= CHANNEL_TOP) ? ch_ff - CHANNEL_TOP : ch_ff;
      ch_next = ch_wrap + CNT_W'(1);
      if (ch_ff <= CNT_W'(1)) begin
         ch_prev = (count == '0) ? CNT_W'(1) : count;
      end else begin
         ch_prev = ch_ff - CNT_W'(1);
      end
   end

   // entry check after the table read
   assign look_ok = (slot_ff < count) && (CNT_W'(tab_rdata) < count);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_BUILD:   state_in = (count == '0) ? ST_RESULT : ST_BUILD;
                  ACT_SHUFFLE: state_in = (cursor_ff == '0) ? ST_RESULT : ST_SW_DIV;
                  ACT_START:   state_in = ST_RD_ISSUE;
                  ACT_NEXT:    state_in = (count == '0) ? ST_RESULT : ST_NX_DIV;
                  ACT_PREV:    state_in = ST_RD_ISSUE;
                  default:     state_in = ST_RESULT;
               endcase
            end
         end
         ST_BUILD: begin
            if (slot_ff == count - CNT_W'(1)) begin
               state_in = ST_RESULT;
            end
         end
         ST_SW_DIV: begin
            if (div_done) begin
               state_in = ST_SW_RD_A;
            end
         end
         ST_SW_RD_A:  state_in = ST_SW_RD_B;
         ST_SW_RD_B:  state_in = ST_SW_WR_A;
         ST_SW_WR_A:  state_in = ST_SW_WR_B;
         ST_SW_WR_B:  state_in = ST_RESULT;
         ST_NX_DIV: begin
            if (div_done) begin
               state_in = ST_RD_ISSUE;
            end
         end
         ST_RD_ISSUE: state_in = ST_RD_CHECK;
         ST_RD_CHECK: state_in = ST_RESULT;
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // table and divider controls
   always_comb begin
      req_stall    = 1'b1;
      tab_we       = 1'b0;
      tab_waddr    = IW'(slot_ff);
      tab_wdata    = IW'(slot_ff);
      tab_raddr    = IW'(slot_ff);
      div_start    = 1'b0;
      div_dividend = req_random_word;
      div_divisor  = cursor_ff + CNT_W'(1);
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (accept && req_action == ACT_SHUFFLE && cursor_ff != '0) begin
               div_start = 1'b1;
            end
            if (accept && req_action == ACT_NEXT && count != '0) begin
               div_start    = 1'b1;
               div_dividend = WORD_W'(pos_ff + CNT_W'(1));
               div_divisor  = count;
            end
         end
         ST_BUILD: begin
            tab_we = 1'b1;
         end
         ST_SW_RD_A: begin
            tab_raddr = IW'(cursor_ff);
         end
         ST_SW_WR_A: begin
            tab_we    = 1'b1;
            tab_waddr = IW'(cursor_ff);
            tab_wdata = tab_rdata;
         end
         ST_SW_WR_B: begin
            tab_we    = 1'b1;
            tab_wdata = tmp_ff;
         end
         default: begin
         end
      endcase
   end

   // control and navigation state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_ff       <= '0;
         pos_ff       <= '0;
         ch_ff        <= CNT_W'(1);
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            csr_ff <= csr_wdata;
         end
         if (accept) begin
            case (req_action)
               ACT_BUILD: begin
                  pos_ff    <= '0;
                  ch_ff     <= CNT_W'(1);
                  cursor_ff <= (count > CNT_W'(1)) ? count - CNT_W'(1) : '0;
               end
               ACT_START: ch_ff <= CNT_W'(1);
               ACT_NEXT: begin
                  ch_ff <= ch_next;
                  if (count == '0) begin
                     pos_ff <= '0;
                  end
               end
               ACT_PREV:  ch_ff <= ch_prev;
               default: begin
               end
            endcase
         end
         if (state_ff == ST_NX_DIV && div_done) begin
            pos_ff <= div_rem;
         end
         if (state_ff == ST_SW_WR_B) begin
            cursor_ff <= cursor_ff - CNT_W'(1);
         end
         // load the response, or drop it once taken
         if (state_ff == ST_RESULT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working registers and response word
   always_ff @(posedge clock) begin
      if (accept) begin
         play_ok_ff <= 1'b0;
         ep_ff      <= '0;
         case (req_action)
            ACT_PREV: slot_ff <= ch_prev - CNT_W'(1);
            default:  slot_ff <= '0;
         endcase
      end
      if (state_ff == ST_BUILD) begin
         slot_ff <= slot_ff + CNT_W'(1);
      end
      if ((state_ff == ST_SW_DIV || state_ff == ST_NX_DIV) && div_done) begin
         slot_ff <= div_rem;
      end
      if (state_ff == ST_SW_RD_B) begin
         tmp_ff <= tab_rdata;
      end
      if (state_ff == ST_RD_CHECK) begin
         play_ok_ff <= look_ok;
         ep_ff      <= look_ok ? tab_rdata : '0;
      end
      if (state_ff == ST_RESULT && out_free) begin
         rsp_ep_ff   <= EP_W'(ep_ff);
         rsp_ok_ff   <= play_ok_ff;
         rsp_ch_ff   <= ch_ff;
         rsp_done_ff <= (cursor_ff == '0);
      end
   end

   pns_tab #(
      .DEPTH (CAP)
   ) u_tab (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (tab_waddr),
      .wr_data (tab_wdata),
      .rd_addr (tab_raddr),
      .rd_data (tab_rdata)
   );

   pns_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_episode_index  = rsp_ep_ff;
   assign rsp_play_valid     = rsp_ok_ff;
   assign rsp_channel_number = rsp_ch_ff;
   assign rsp_shuffle_done   = rsp_done_ff;

   // remainder unit finishes only while the sequencer waits for it
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_SW_DIV || state_ff == ST_NX_DIV))
      else $error("remainder finished outside a wait state");

   // a swap lowers the cursor by exactly one
   a_cursor_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SW_WR_B |=> cursor_ff == $past(cursor_ff) - CNT_W'(1))
      else $error("shuffle cursor did not step down by one");

   // channel never reaches zero
   a_channel_nonzero: assert property (@(posedge clock) disable iff (reset)
      ch_ff != '0)
      else $error("channel became zero");

   // a finished request always produces a response word
   a_result_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && out_free) |=> rsp_valid_ff)
      else $error("response not loaded");

endmodule

`default_nettype wire
